// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the leg kinematics core. Each macro samples on
// the rising edge of clk and is held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every sampled edge out of reset.
`define LIK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lik assertion failed");
// Condition must never be seen out of reset.
`define LIK_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lik forbidden condition seen");
`else
`define LIK_ASSERT(lbl, prop)
`define LIK_NEVER(lbl, cond)
`endif

`endif

// File: rtl/core/lik_pkg.sv
// ---------------------------------------------------------------------------
// lik_pkg
// Types, constants and tables shared by the leg kinematics core.
// ---------------------------------------------------------------------------
package lik_pkg;

    localparam int CoordW  = 16;
    localparam int LenW    = 14;
    localparam int OffW    = 16;
    localparam int AngW    = 16;
    localparam int JointW  = 17;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    // Register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_COXA     = 3'd0,
        CFG_FEMUR    = 3'd1,
        CFG_TIBIA    = 3'd2,
        CFG_ELBOW    = 3'd3,
        CFG_SHOULDER = 3'd4
    } cfg_index_t;

    localparam logic [LenW-1:0] CoxaReset  = 14'd0;
    localparam logic [LenW-1:0] FemurReset = 14'd1600;
    localparam logic [LenW-1:0] TibiaReset = 14'd1600;

    typedef struct packed {
        logic [LenW-1:0]        coxa;
        logic [LenW-1:0]        femur;
        logic [LenW-1:0]        tibia;
        logic signed [OffW-1:0] elbow_off;
        logic signed [OffW-1:0] shoulder_off;
    } cfg_t;

    // Planar terms of the law of cosines, 30 bits each when in reach
    localparam int TermW = 30;

    typedef struct packed {
        logic                   unreachable;
        logic [TermW-1:0]       a;
        logic [TermW-1:0]       b;
        logic signed [AngW-1:0] alpha;
        logic signed [AngW-1:0] yaw;
    } ik_entry_t;

    // Queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    // Square root unit: 64-bit radicand, one root bit per cycle
    localparam int SqrtInW  = 64;
    localparam int SqrtOutW = 32;
    localparam int SqrtCntW = 5;
    localparam logic [SqrtCntW-1:0] SqrtLast = 5'd31;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sqrt_state_t;

    // Vectoring CORDIC
    localparam int VecW        = 48;
    localparam int RotW        = 34;
    localparam int ZW          = 32;
    localparam int CordicIterW = 5;
    localparam logic [CordicIterW-1:0] CordicLast = 5'd19;
    localparam logic [VecW-1:0] MagCoarseHi = 48'd1 << 34;
    localparam logic [VecW-1:0] MagHi       = 48'd1 << 30;
    localparam logic [VecW-1:0] MagLo       = 48'd1 << 29;
    localparam logic [VecW-1:0] MagCoarseLo = 48'd1 << 25;
    localparam logic signed [ZW-1:0] ZMax   = 32'sd589824000;
    localparam logic signed [ZW-1:0] ZRound = 32'sd32768;
    localparam logic signed [AngW-1:0] HalfTurn = 16'sd18000;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_NORM,
        CD_ITER,
        CD_FIN
    } cordic_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_HSQ,
        F_ROOT,
        F_RSQ,
        F_RSUM,
        F_CLS,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SQS,
        B_ROOT,
        B_PROD,
        B_VEC,
        B_ATAN,
        B_WAIT
    } back_state_t;

    localparam logic signed [17:0] AngLimit = 18'sd54000;

    // atan(2^-i) in 2^-16 centidegree units
    function automatic logic signed [ZW-1:0] atan_step(input logic [CordicIterW-1:0] idx);
        case (idx)
            5'd0:    return 32'sd294912000;
            5'd1:    return 32'sd174096719;
            5'd2:    return 32'sd91987925;
            5'd3:    return 32'sd46694507;
            5'd4:    return 32'sd23437865;
            5'd5:    return 32'sd11730358;
            5'd6:    return 32'sd5866610;
            5'd7:    return 32'sd2933484;
            5'd8:    return 32'sd1466764;
            5'd9:    return 32'sd733385;
            5'd10:   return 32'sd366693;
            5'd11:   return 32'sd183346;
            5'd12:   return 32'sd91673;
            5'd13:   return 32'sd45837;
            5'd14:   return 32'sd22918;
            5'd15:   return 32'sd11459;
            5'd16:   return 32'sd5730;
            5'd17:   return 32'sd2865;
            5'd18:   return 32'sd1432;
            5'd19:   return 32'sd716;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

// File: rtl/core/lik_isqrt.sv
// ---------------------------------------------------------------------------
// lik_isqrt
// Floor square root of a 64-bit word, one root bit per cycle.
// ---------------------------------------------------------------------------
module lik_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lik_pkg::SqrtInW-1:0]   operand,
    output logic                          busy,
    output logic [lik_pkg::SqrtOutW-1:0]  root
);

    lik_pkg::sqrt_state_t             state_reg, state_next;
    logic [lik_pkg::SqrtCntW-1:0]     cnt_reg;
    logic [lik_pkg::SqrtInW-1:0]      op_reg;
    logic [lik_pkg::SqrtOutW+3:0]     rem_reg;
    logic [lik_pkg::SqrtOutW-1:0]     root_reg;
    logic [lik_pkg::SqrtOutW+3:0]     rem_sh;
    logic [lik_pkg::SqrtOutW+3:0]     trial;
    logic                             fits;

    assign rem_sh = {rem_reg[lik_pkg::SqrtOutW+1:0], op_reg[lik_pkg::SqrtInW-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lik_pkg::SQ_IDLE:
            begin
                if (start)
                    state_next = lik_pkg::SQ_RUN;
            end
            lik_pkg::SQ_RUN:
            begin
                if (cnt_reg == lik_pkg::SqrtLast)
                    state_next = lik_pkg::SQ_IDLE;
            end
            default: state_next = lik_pkg::SQ_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg == lik_pkg::SQ_RUN);
        root = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lik_pkg::SQ_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lik_pkg::SQ_IDLE)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lik_pkg::SQ_IDLE)
        begin
            if (start)
            begin
                op_reg   <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        else
        begin
            op_reg   <= {op_reg[lik_pkg::SqrtInW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[lik_pkg::SqrtOutW-2:0], fits};
        end
    end

endmodule

// File: rtl/core/lik_atan2.sv
// ---------------------------------------------------------------------------
// lik_atan2
// Four-quadrant atan2 in centidegrees: coarse/fine normalization, then a
// 20-step vectoring CORDIC in the first quadrant, round and mirror.
// ---------------------------------------------------------------------------
module lik_atan2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lik_pkg::VecW-1:0]   y_in,
    input  logic signed [lik_pkg::VecW-1:0]   x_in,
    output logic                              busy,
    output logic signed [lik_pkg::AngW-1:0]   angle
);

    lik_pkg::cordic_state_t               state_reg, state_next;
    logic [lik_pkg::VecW-1:0]             ax_reg, ay_reg;
    logic                                 xneg_reg, yneg_reg;
    logic signed [lik_pkg::RotW-1:0]      cx_reg, cy_reg;
    logic signed [lik_pkg::ZW-1:0]        z_reg;
    logic [lik_pkg::CordicIterW-1:0]      i_reg;
    logic signed [lik_pkg::AngW-1:0]      angle_reg;

    logic [lik_pkg::VecW-1:0]             ax_in, ay_in, mag;
    logic                                 zero_in, in_range;
    logic signed [lik_pkg::RotW-1:0]      dx, dy;
    logic signed [lik_pkg::ZW-1:0]        zc, zsum;
    logic [13:0]                          q;
    logic signed [lik_pkg::AngW-1:0]      q_mir, q_fin;

    assign ax_in    = x_in[lik_pkg::VecW-1] ? lik_pkg::VecW'(-x_in) : lik_pkg::VecW'(x_in);
    assign ay_in    = y_in[lik_pkg::VecW-1] ? lik_pkg::VecW'(-y_in) : lik_pkg::VecW'(y_in);
    assign zero_in  = (x_in == '0) && (y_in == '0);
    assign mag      = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign in_range = (mag < lik_pkg::MagHi) && (mag >= lik_pkg::MagLo);
    assign dx       = cy_reg >>> i_reg;
    assign dy       = cx_reg >>> i_reg;

    always_comb
    begin
        if (z_reg < 0)
            zc = '0;
        else if (z_reg > lik_pkg::ZMax)
            zc = lik_pkg::ZMax;
        else
            zc = z_reg;
        zsum  = zc + lik_pkg::ZRound;
        q     = zsum[29:16];
        q_mir = xneg_reg ? (lik_pkg::HalfTurn - signed'({2'b00, q})) : signed'({2'b00, q});
        q_fin = yneg_reg ? -q_mir : q_mir;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lik_pkg::CD_IDLE:
            begin
                if (start)
                    state_next = zero_in ? lik_pkg::CD_FIN : lik_pkg::CD_NORM;
            end
            lik_pkg::CD_NORM:
            begin
                if (in_range)
                    state_next = lik_pkg::CD_ITER;
            end
            lik_pkg::CD_ITER:
            begin
                if (i_reg == lik_pkg::CordicLast)
                    state_next = lik_pkg::CD_FIN;
            end
            lik_pkg::CD_FIN: state_next = lik_pkg::CD_IDLE;
            default:         state_next = lik_pkg::CD_IDLE;
        endcase
    end

    always_comb
    begin
        busy  = (state_reg != lik_pkg::CD_IDLE);
        angle = angle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lik_pkg::CD_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lik_pkg::CD_IDLE:
            begin
                if (start)
                begin
                    ax_reg   <= ax_in;
                    ay_reg   <= ay_in;
                    xneg_reg <= x_in[lik_pkg::VecW-1];
                    yneg_reg <= y_in[lik_pkg::VecW-1];
                    z_reg    <= '0;
                end
            end
            lik_pkg::CD_NORM:
            begin
                // big steps first, then single bits into [2^29, 2^30)
                if (mag >= lik_pkg::MagCoarseHi)
                begin
                    ax_reg <= ax_reg >> 4;
                    ay_reg <= ay_reg >> 4;
                end
                else if (mag >= lik_pkg::MagHi)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (mag < lik_pkg::MagCoarseLo)
                begin
                    ax_reg <= ax_reg << 4;
                    ay_reg <= ay_reg << 4;
                end
                else if (mag < lik_pkg::MagLo)
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
                else
                begin
                    cx_reg <= signed'({4'b0000, ax_reg[29:0]});
                    cy_reg <= signed'({4'b0000, ay_reg[29:0]});
                    i_reg  <= '0;
                end
            end
            lik_pkg::CD_ITER:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + lik_pkg::atan_step(i_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - lik_pkg::atan_step(i_reg);
                end
                i_reg <= i_reg + 1'b1;
            end
            lik_pkg::CD_FIN: angle_reg <= q_fin;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/lik_front.sv
// ---------------------------------------------------------------------------
// lik_front
// Takes a target word, finds horizontal reach, planar distance, reach class,
// the cosine-law terms, yaw and the line angle, and queues the result.
// ---------------------------------------------------------------------------
module lik_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [lik_pkg::CoordW-1:0]     target_x,
    input  logic signed [lik_pkg::CoordW-1:0]     target_y,
    input  logic signed [lik_pkg::CoordW-1:0]     target_z,
    input  lik_pkg::cfg_t                         cfg,
    input  logic                                  q_full,
    output logic                                  busy,
    output logic                                  push,
    output lik_pkg::ik_entry_t                    entry
);

    localparam int ExtW = lik_pkg::VecW - lik_pkg::CoordW;

    lik_pkg::front_state_t                state_reg, state_next;
    logic signed [lik_pkg::CoordW-1:0]    x_reg, y_reg, z_reg;
    logic [31:0]                          xsq_reg, ysq_reg;
    logic signed [20:0]                   x1_reg;
    logic signed [19:0]                   z1_reg;
    logic [41:0]                          x1sq_reg;
    logic [39:0]                          z1sq_reg;
    logic [37:0]                          sumsq_reg, diffsq_reg;
    logic [41:0]                          r2_reg;
    logic                                 flag_reg;
    logic [lik_pkg::TermW-1:0]            a_reg, b_reg;

    logic                                 accept, yaw_start, sqrt_start, alpha_start;
    logic                                 yaw_busy, alpha_busy, sqrt_busy;
    logic signed [lik_pkg::AngW-1:0]      yaw_angle, alpha_angle;
    logic [lik_pkg::SqrtOutW-1:0]         root;
    logic [31:0]                          hsq;
    logic signed [31:0]                   xsq_s, ysq_s;
    logic signed [41:0]                   x1sq_s;
    logic signed [39:0]                   z1sq_s;
    logic [14:0]                          len_sum;
    logic [13:0]                          len_diff;
    logic [18:0]                          big_sum;
    logic [17:0]                          big_diff;
    logic [41:0]                          a_full, b_full;

    assign hsq      = xsq_reg + ysq_reg;
    assign xsq_s    = x_reg * x_reg;
    assign ysq_s    = y_reg * y_reg;
    assign x1sq_s   = x1_reg * x1_reg;
    assign z1sq_s   = z1_reg * z1_reg;
    assign len_sum  = {1'b0, cfg.femur} + {1'b0, cfg.tibia};
    assign len_diff = (cfg.femur >= cfg.tibia) ? (cfg.femur - cfg.tibia)
                                               : (cfg.tibia - cfg.femur);
    assign big_sum  = {len_sum, 4'b0000};
    assign big_diff = {len_diff, 4'b0000};
    assign a_full   = {4'b0000, sumsq_reg} - r2_reg;
    assign b_full   = r2_reg - {4'b0000, diffsq_reg};

    lik_isqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand ({24'd0, hsq, 8'd0}),
        .busy    (sqrt_busy),
        .root    (root)
    );

    lik_atan2 u_yaw (
        .clk   (clk),
        .rst_n (rst_n),
        .start (yaw_start),
        .y_in  ({{ExtW{target_y[lik_pkg::CoordW-1]}}, target_y}),
        .x_in  ({{ExtW{target_x[lik_pkg::CoordW-1]}}, target_x}),
        .busy  (yaw_busy),
        .angle (yaw_angle)
    );

    lik_atan2 u_alpha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alpha_start),
        .y_in  ({{28{z1_reg[19]}}, z1_reg}),
        .x_in  ({{27{x1_reg[20]}}, x1_reg}),
        .busy  (alpha_busy),
        .angle (alpha_angle)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lik_pkg::F_IDLE: if (start) state_next = lik_pkg::F_SQ;
            lik_pkg::F_SQ:   state_next = lik_pkg::F_HSQ;
            lik_pkg::F_HSQ:  state_next = lik_pkg::F_ROOT;
            lik_pkg::F_ROOT: if (!sqrt_busy) state_next = lik_pkg::F_RSQ;
            lik_pkg::F_RSQ:  state_next = lik_pkg::F_RSUM;
            lik_pkg::F_RSUM: state_next = lik_pkg::F_CLS;
            lik_pkg::F_CLS:  state_next = lik_pkg::F_PUSH;
            lik_pkg::F_PUSH:
            begin
                if (!yaw_busy && !alpha_busy && !q_full)
                    state_next = lik_pkg::F_IDLE;
            end
            default: state_next = lik_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != lik_pkg::F_IDLE);
        accept      = (state_reg == lik_pkg::F_IDLE) && start;
        yaw_start   = accept;
        sqrt_start  = (state_reg == lik_pkg::F_HSQ);
        alpha_start = (state_reg == lik_pkg::F_RSQ);
        push        = (state_reg == lik_pkg::F_PUSH) && !yaw_busy && !alpha_busy && !q_full;
        entry.unreachable = flag_reg;
        entry.a           = a_reg;
        entry.b           = b_reg;
        entry.alpha       = alpha_angle;
        entry.yaw         = yaw_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lik_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lik_pkg::F_IDLE:
            begin
                if (start)
                begin
                    x_reg <= target_x;
                    y_reg <= target_y;
                    z_reg <= target_z;
                end
            end
            lik_pkg::F_SQ:
            begin
                xsq_reg <= 32'(xsq_s);
                ysq_reg <= 32'(ysq_s);
            end
            lik_pkg::F_ROOT:
            begin
                x1_reg <= signed'({1'b0, root[19:0]}) - signed'({3'b000, cfg.coxa, 4'b0000});
                z1_reg <= {z_reg, 4'b0000};
            end
            lik_pkg::F_RSQ:
            begin
                x1sq_reg   <= 42'(x1sq_s);
                z1sq_reg   <= 40'(z1sq_s);
                sumsq_reg  <= big_sum * big_sum;
                diffsq_reg <= 38'(big_diff * big_diff);
            end
            lik_pkg::F_RSUM: r2_reg <= x1sq_reg + {2'b00, z1sq_reg};
            lik_pkg::F_CLS:
            begin
                flag_reg <= (r2_reg > {4'b0000, sumsq_reg}) || (r2_reg < {4'b0000, diffsq_reg});
                a_reg    <= a_full[37:8];
                b_reg    <= b_full[37:8];
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/lik_queue.sv
// ---------------------------------------------------------------------------
// lik_queue
// Four-word queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lik_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lik_pkg::ik_entry_t wr_entry,
    input  logic               pop,
    output lik_pkg::ik_entry_t rd_entry,
    output logic               full,
    output logic               empty
);

    lik_pkg::ik_entry_t             slot_reg [lik_pkg::QDepth];
    logic [lik_pkg::QPtrW-1:0]      wptr_reg, rptr_reg;
    logic [lik_pkg::QCntW-1:0]      count_reg;

    assign full     = (count_reg == lik_pkg::QCntW'(lik_pkg::QDepth));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wr_entry;
    end

    `LIK_NEVER(a_no_push_full, push && full)
    `LIK_NEVER(a_no_pop_empty, pop && empty)
    `LIK_ASSERT(a_count_bound, count_reg <= lik_pkg::QCntW'(lik_pkg::QDepth))

endmodule

// File: rtl/core/lik_back.sv
// ---------------------------------------------------------------------------
// lik_back
// Takes a queued word, finds the half-chord s, the elbow and femur angles,
// applies offsets and saturation, and strobes the joint angles out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lik_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lik_pkg::cfg_t                        cfg,
    input  logic                                 q_empty,
    input  lik_pkg::ik_entry_t                   q_entry,
    output logic                                 pop,
    output logic                                 result_valid,
    output logic signed [lik_pkg::JointW-1:0]    knee_angle,
    output logic signed [lik_pkg::JointW-1:0]    hip_pitch_angle,
    output logic signed [lik_pkg::AngW-1:0]      hip_yaw_angle,
    output logic                                 unreachable
);

    lik_pkg::back_state_t                 state_reg, state_next;
    lik_pkg::ik_entry_t                   ent_reg;
    logic [59:0]                          prod_reg;
    logic [30:0]                          s_reg;
    logic [44:0]                          l3s_reg, lab_reg;
    logic signed [45:0]                   l3d_reg;
    logic signed [lik_pkg::VecW-1:0]      yb_reg, xb_reg;
    logic                                 valid_reg;
    logic signed [lik_pkg::JointW-1:0]    knee_reg, pitch_reg;
    logic signed [lik_pkg::AngW-1:0]      yaw_reg;
    logic                                 flag_reg;

    logic                                 sqrt_start, sqrt_busy, cd_start, phi_busy, beta_busy;
    logic                                 finish;
    logic [lik_pkg::SqrtOutW-1:0]         root;
    logic [30:0]                          apb;
    logic signed [30:0]                   bma;
    logic signed [lik_pkg::AngW-1:0]      phi, beta;
    logic signed [17:0]                   knee_raw, pitch_raw;

    function automatic logic signed [lik_pkg::JointW-1:0] sat_ang(input logic signed [17:0] v);
        if (v > lik_pkg::AngLimit)
            return lik_pkg::JointW'(lik_pkg::AngLimit);
        else if (v < -lik_pkg::AngLimit)
            return lik_pkg::JointW'(-lik_pkg::AngLimit);
        else
            return v[lik_pkg::JointW-1:0];
    endfunction

    assign apb       = {1'b0, ent_reg.a} + {1'b0, ent_reg.b};
    assign bma       = signed'({1'b0, ent_reg.b}) - signed'({1'b0, ent_reg.a});
    assign knee_raw  = {{2{phi[15]}}, phi} - {{2{cfg.elbow_off[15]}}, cfg.elbow_off};
    assign pitch_raw = {{2{ent_reg.alpha[15]}}, ent_reg.alpha} + {{2{beta[15]}}, beta}
                     + {{2{cfg.shoulder_off[15]}}, cfg.shoulder_off};

    lik_isqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand ({4'b0000, prod_reg}),
        .busy    (sqrt_busy),
        .root    (root)
    );

    lik_atan2 u_phi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .y_in  (signed'({16'd0, s_reg, 1'b0})),
        .x_in  ({{17{bma[30]}}, bma}),
        .busy  (phi_busy),
        .angle (phi)
    );

    lik_atan2 u_beta (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .y_in  (yb_reg),
        .x_in  (xb_reg),
        .busy  (beta_busy),
        .angle (beta)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lik_pkg::B_IDLE: if (!q_empty) state_next = lik_pkg::B_MUL;
            lik_pkg::B_MUL:  state_next = lik_pkg::B_SQS;
            lik_pkg::B_SQS:  state_next = lik_pkg::B_ROOT;
            lik_pkg::B_ROOT: if (!sqrt_busy) state_next = lik_pkg::B_PROD;
            lik_pkg::B_PROD: state_next = lik_pkg::B_VEC;
            lik_pkg::B_VEC:  state_next = lik_pkg::B_ATAN;
            lik_pkg::B_ATAN: state_next = lik_pkg::B_WAIT;
            lik_pkg::B_WAIT: if (!phi_busy && !beta_busy) state_next = lik_pkg::B_IDLE;
            default:         state_next = lik_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = (state_reg == lik_pkg::B_IDLE) && !q_empty;
        sqrt_start = (state_reg == lik_pkg::B_SQS);
        cd_start   = (state_reg == lik_pkg::B_ATAN);
        finish     = (state_reg == lik_pkg::B_WAIT) && !phi_busy && !beta_busy;
        result_valid    = valid_reg;
        knee_angle      = knee_reg;
        hip_pitch_angle = pitch_reg;
        hip_yaw_angle   = yaw_reg;
        unreachable     = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lik_pkg::B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lik_pkg::B_IDLE: if (!q_empty) ent_reg <= q_entry;
            lik_pkg::B_MUL:  prod_reg <= ent_reg.a * ent_reg.b;
            lik_pkg::B_ROOT: s_reg <= root[30:0];
            lik_pkg::B_PROD:
            begin
                l3s_reg <= cfg.tibia * s_reg;
                lab_reg <= cfg.femur * apb;
                l3d_reg <= signed'({1'b0, cfg.tibia}) * bma;
            end
            lik_pkg::B_VEC:
            begin
                yb_reg <= signed'({2'b00, l3s_reg, 1'b0});
                xb_reg <= signed'({3'b000, lab_reg}) + {{2{l3d_reg[45]}}, l3d_reg};
            end
            lik_pkg::B_WAIT:
            begin
                // out of reach: zero angles in place of the throw
                if (finish)
                begin
                    flag_reg  <= ent_reg.unreachable;
                    knee_reg  <= ent_reg.unreachable ? '0 : sat_ang(knee_raw);
                    pitch_reg <= ent_reg.unreachable ? '0 : sat_ang(pitch_raw);
                    yaw_reg   <= ent_reg.unreachable ? '0 : ent_reg.yaw;
                end
            end
            default: ;
        endcase
    end

    `LIK_ASSERT(a_valid_pulse, result_valid |=> !result_valid)
    `LIK_ASSERT(a_unreach_zero, (result_valid && unreachable) |->
        (knee_angle == '0 && hip_pitch_angle == '0 && hip_yaw_angle == '0))
    `LIK_NEVER(a_no_pop_busy, pop && (state_reg != lik_pkg::B_IDLE))

endmodule

// File: rtl/core/leg_inverse_kinematics_core.sv
// ---------------------------------------------------------------------------
// leg_inverse_kinematics_core
// Three-joint leg inverse kinematics: foot target in, joint angles out.
// ---------------------------------------------------------------------------
// The time from the accepting edge to result_valid depends on the CORDIC
// normalize steps and grows while words wait in the queue. The back part
// bounds the rate: a square root, then two CORDIC passes in parallel. The
// front takes a new target after queuing the last; busy is high until then.
// Reset loads the register defaults and empties the queue; no clearing pass.
// Results are strobed for one cycle and the receiver cannot stall.
module leg_inverse_kinematics_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [lik_pkg::CoordW-1:0]        target_x,
    input  logic signed [lik_pkg::CoordW-1:0]        target_y,
    input  logic signed [lik_pkg::CoordW-1:0]        target_z,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [lik_pkg::CfgIdxW-1:0]              cfg_index,
    input  logic [lik_pkg::CfgDataW-1:0]             cfg_data,
    output logic                                     result_valid,
    output logic signed [lik_pkg::JointW-1:0]        knee_angle,
    output logic signed [lik_pkg::JointW-1:0]        hip_pitch_angle,
    output logic signed [lik_pkg::AngW-1:0]          hip_yaw_angle,
    output logic                                     unreachable
);

    lik_pkg::cfg_t          cfg_reg;
    lik_pkg::ik_entry_t     push_entry, pop_entry;
    logic                   push, pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coxa         <= lik_pkg::CoxaReset;
            cfg_reg.femur        <= lik_pkg::FemurReset;
            cfg_reg.tibia        <= lik_pkg::TibiaReset;
            cfg_reg.elbow_off    <= '0;
            cfg_reg.shoulder_off <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lik_pkg::CFG_COXA:     cfg_reg.coxa         <= cfg_data[lik_pkg::LenW-1:0];
                lik_pkg::CFG_FEMUR:    cfg_reg.femur        <= cfg_data[lik_pkg::LenW-1:0];
                lik_pkg::CFG_TIBIA:    cfg_reg.tibia        <= cfg_data[lik_pkg::LenW-1:0];
                lik_pkg::CFG_ELBOW:    cfg_reg.elbow_off    <= signed'(cfg_data);
                lik_pkg::CFG_SHOULDER: cfg_reg.shoulder_off <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    lik_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .entry    (push_entry)
    );

    lik_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (push_entry),
        .pop      (pop),
        .rd_entry (pop_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    lik_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_entry         (pop_entry),
        .pop             (pop),
        .result_valid    (result_valid),
        .knee_angle      (knee_angle),
        .hip_pitch_angle (hip_pitch_angle),
        .hip_yaw_angle   (hip_yaw_angle),
        .unreachable     (unreachable)
    );

endmodule
